@@ hdl/smmas_pkg.sv @@
// Shared types, widths and helpers for the sample min/max/average statistics block.
// No dependencies; every other file in hdl/ imports this package.
package smmas_pkg;

    localparam int CODE_W    = 12;
    localparam int COUNT_W   = 20;
    localparam int SUM_W     = 32;
    localparam int VREF_W    = 13;
    localparam int MV_W      = 13;
    localparam int PROD_W    = CODE_W + VREF_W;
    localparam int STEP_W    = $clog2(SUM_W);

    localparam logic [CODE_W-1:0]  CODE_FS    = {CODE_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [VREF_W-1:0]  VREF_RESET = VREF_W'(3300);

    localparam logic [STEP_W-1:0]  DIV_LAST   = STEP_W'(SUM_W - 1);
    localparam logic [STEP_W-1:0]  CONV_LAST  = STEP_W'(3);

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic [1:0] SEL_MIN = 2'd0;
    localparam logic [1:0] SEL_MAX = 2'd1;
    localparam logic [1:0] SEL_AVG = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [CODE_W-1:0] sample;
    } in_beat_t;

    typedef struct packed {
        logic [MV_W-1:0]    min_mv;
        logic [MV_W-1:0]    max_mv;
        logic [MV_W-1:0]    peak_to_peak_mv;
        logic [MV_W-1:0]    average_mv;
        logic [COUNT_W-1:0] sample_count;
        logic               overflowed;
    } out_beat_t;

    typedef struct packed {
        logic       add_sample;
        logic       snap;
        logic       clear;
        logic       div_step;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       scale_en;
        logic [1:0] scale_sel;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic stats_empty;
        logic out_free;
    } sts_t;

    // Divide a product by full scale (2^CODE_W - 1) with two fold steps and one fix.
    function automatic logic [MV_W-1:0] scale_to_mv(input logic [PROD_W-1:0] prod);
        logic [PROD_W-CODE_W-1:0] q1;
        logic [PROD_W-CODE_W:0]   r1;
        logic [1:0]               q2;
        logic [CODE_W:0]          r2;
        logic                     fix;
        q1  = prod[PROD_W-1:CODE_W];
        r1  = {1'b0, q1} + (PROD_W-CODE_W+1)'(prod[CODE_W-1:0]);
        q2  = r1[CODE_W+1:CODE_W];
        r2  = {1'b0, r1[CODE_W-1:0]} + (CODE_W+1)'(q2);
        fix = (r2 >= {1'b0, CODE_FS});
        return MV_W'(q1) + MV_W'(q2) + MV_W'(fix);
    endfunction

endpackage

@@ hdl/smmas_ctrl.sv @@
// Sequencer for the statistics block: sample intake, report division, scaling, beat hand-off.
// Depends on smmas_pkg; drives smmas_dp through cmd_t and reads sts_t.
module smmas_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              in_op,
    input  smmas_pkg::sts_t   sts,
    output smmas_pkg::cmd_t   cmd
);
    import smmas_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_CONV = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        cmd.mul_sel    = step_reg[1:0];
        cmd.scale_sel  = step_reg[1:0] - 2'd1;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_op == OP_ADD) begin
                        cmd.add_sample = 1'b1;
                    end else begin
                        cmd.clear = 1'b1;
                        if (!sts.stats_empty) begin
                            cmd.snap   = 1'b1;
                            step_next  = '0;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIV_LAST) begin
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.mul_en   = (step_reg != CONV_LAST);
                cmd.scale_en = (step_reg != '0);
                step_next    = step_reg + 1'b1;
                if (step_reg == CONV_LAST) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ hdl/smmas_dp.sv @@
// Datapath for the statistics block: running stats, snapshot, serial divider, scaler, output beat.
// Depends on smmas_pkg; commanded by smmas_ctrl.
module smmas_dp (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic [smmas_pkg::VREF_W-1:0] cfg_data,
    input  smmas_pkg::in_beat_t      s_data,
    input  smmas_pkg::cmd_t          cmd,
    output smmas_pkg::sts_t          sts,
    output logic                     m_valid,
    input  logic                     m_ready,
    output smmas_pkg::out_beat_t     m_data
);
    import smmas_pkg::*;

    logic [VREF_W-1:0]  vref_reg;
    logic [CODE_W-1:0]  min_reg, max_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               drop_reg;

    logic [CODE_W-1:0]  snap_min_reg, snap_max_reg;
    logic [COUNT_W-1:0] snap_cnt_reg;
    logic               snap_drop_reg;

    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W:0]   rem_sh;

    logic [PROD_W-1:0]  prod_reg;
    logic [CODE_W-1:0]  mul_code;
    logic [MV_W-1:0]    min_mv_reg, max_mv_reg, avg_mv_reg, scaled;

    logic               m_valid_reg;
    out_beat_t          m_data_reg;
    logic [SUM_W:0]     sum_ext;

    assign sum_ext = {1'b0, sum_reg} + (SUM_W+1)'(s_data.sample);

    assign sts.stats_empty = (count_reg == '0);
    assign sts.out_free    = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        rem_sh = {rem_reg, quo_reg[SUM_W-1]};
        if (rem_sh >= {1'b0, snap_cnt_reg}) begin
            rem_next = COUNT_W'(rem_sh - {1'b0, snap_cnt_reg});
            quo_next = {quo_reg[SUM_W-2:0], 1'b1};
        end else begin
            rem_next = rem_sh[COUNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], 1'b0};
        end
    end

    always_comb begin
        unique case (cmd.mul_sel)
            SEL_MIN: mul_code = snap_min_reg;
            SEL_MAX: mul_code = snap_max_reg;
            default: mul_code = quo_reg[CODE_W-1:0];
        endcase
    end

    assign scaled = scale_to_mv(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vref_reg  <= VREF_RESET;
            min_reg   <= CODE_FS;
            max_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                vref_reg <= cfg_data;
            end
            if (cmd.clear) begin
                min_reg   <= CODE_FS;
                max_reg   <= '0;
                sum_reg   <= '0;
                count_reg <= '0;
                drop_reg  <= 1'b0;
            end else if (cmd.add_sample) begin
                if (count_reg == COUNT_MAX) begin
                    drop_reg <= 1'b1;
                end else begin
                    if (s_data.sample < min_reg) begin
                        min_reg <= s_data.sample;
                    end
                    if (s_data.sample > max_reg) begin
                        max_reg <= s_data.sample;
                    end
                    sum_reg   <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.snap) begin
            snap_min_reg  <= min_reg;
            snap_max_reg  <= max_reg;
            snap_cnt_reg  <= count_reg;
            snap_drop_reg <= drop_reg;
            quo_reg       <= sum_reg;
            rem_reg       <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.mul_en) begin
            prod_reg <= PROD_W'(mul_code) * PROD_W'(vref_reg);
        end
        if (cmd.scale_en) begin
            unique case (cmd.scale_sel)
                SEL_MIN: min_mv_reg <= scaled;
                SEL_MAX: max_mv_reg <= scaled;
                default: avg_mv_reg <= scaled;
            endcase
        end
        if (cmd.load_out) begin
            m_data_reg.min_mv          <= min_mv_reg;
            m_data_reg.max_mv          <= max_mv_reg;
            m_data_reg.peak_to_peak_mv <= (max_mv_reg >= min_mv_reg) ?
                                          (max_mv_reg - min_mv_reg) : '0;
            m_data_reg.average_mv      <= avg_mv_reg;
            m_data_reg.sample_count    <= snap_cnt_reg;
            m_data_reg.overflowed      <= snap_drop_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

endmodule

@@ hdl/sample_min_max_avg_stats_top.sv @@
// Top level of the sample min/max/average statistics block.
// Depends on smmas_pkg, smmas_ctrl and smmas_dp.
//
//   channel | ports                      | beat
//   --------+----------------------------+-------------------------------------
//   input   | s_valid s_ready s_data     | operation, sample
//   result  | m_valid m_ready m_data     | min/max/p-p/average mV, count, flag
//   config  | cfg_valid cfg_ready cfg_data | vref_mv (13 bits)
//
// Sample beats are taken one per cycle while no report is in progress;
// the stats update in that cycle. A report beat snapshots the stats, then
// runs the bit-serial sum/count divider and the shared multiplier and scaler
// before its result beat is loaded. A report with no samples only clears.
// Samples keep flowing while a result beat waits on m_ready; the next report
// holds in its last step until the output register frees.
// aresetn is synchronous, active low; vref resets to 3300 mV.
module sample_min_max_avg_stats_top (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [smmas_pkg::VREF_W-1:0] cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  smmas_pkg::in_beat_t      s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output smmas_pkg::out_beat_t     m_data
);
    import smmas_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    smmas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_op   (s_data.operation),
        .sts     (sts),
        .cmd     (cmd)
    );

    smmas_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ tb/tb.sv @@
// Testbench for sample_min_max_avg_stats_top: directed and random sample/report beats,
// each report checked against an in-bench statistics predictor.
// Depends on smmas_pkg and the RTL in hdl/.
module tb;
    import smmas_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int QUEUE_DEPTH = 64;
    localparam int SETTLE_CYCLES = 40;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [VREF_W-1:0]   cfg_data  = VREF_RESET;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_beat_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b1;
    out_beat_t           m_data;

    in_beat_t            beat_q[$];
    out_beat_t           report_q[$];

    int                  send_gap_max   = 3;
    int                  recv_stall_max = 6;
    int                  idle_left      = 0;
    int                  stall_left     = 0;
    int                  bad_reports    = 0;
    int                  cycles         = 0;

    logic [VREF_W-1:0]   vref_now;
    logic [CODE_W-1:0]   acc_min;
    logic [CODE_W-1:0]   acc_max;
    logic [SUM_W-1:0]    acc_sum;
    logic [COUNT_W-1:0]  acc_count;
    logic                acc_dropped;

    sample_min_max_avg_stats_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [MV_W-1:0] code_to_mv(input logic [CODE_W-1:0] code);
        int unsigned prod;
        prod = int'(code) * int'(vref_now);
        return MV_W'(prod / int'(CODE_FS));
    endfunction

    function automatic void clear_stats();
        acc_min     = CODE_FS;
        acc_max     = '0;
        acc_sum     = '0;
        acc_count   = '0;
        acc_dropped = 1'b0;
    endfunction

    function automatic void absorb_beat(input in_beat_t b);
        out_beat_t r;
        if (b.operation == OP_ADD) begin
            if (acc_count == COUNT_MAX) begin
                acc_dropped = 1'b1;
            end else begin
                if (b.sample < acc_min) acc_min = b.sample;
                if (b.sample > acc_max) acc_max = b.sample;
                if (33'(acc_sum) + 33'(b.sample) > 33'(SUM_MAX))
                    acc_sum = SUM_MAX;
                else
                    acc_sum = acc_sum + SUM_W'(b.sample);
                acc_count = acc_count + 1'b1;
            end
        end else begin
            if (acc_count != 0) begin
                r.min_mv          = code_to_mv(acc_min);
                r.max_mv          = code_to_mv(acc_max);
                r.peak_to_peak_mv = (r.max_mv >= r.min_mv) ? r.max_mv - r.min_mv : '0;
                r.average_mv      = code_to_mv(CODE_W'(acc_sum / SUM_W'(acc_count)));
                r.sample_count    = acc_count;
                r.overflowed      = acc_dropped;
                report_q.push_back(r);
            end
            clear_stats();
        end
    endfunction

    // Sender: one gap drawn per beat, payload held until accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            idle_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (idle_left != 0) begin
                s_valid   <= 1'b0;
                idle_left <= idle_left - 1;
            end else if (beat_q.size() != 0) begin
                s_valid   <= 1'b1;
                s_data    <= beat_q.pop_front();
                idle_left <= $urandom_range(0, send_gap_max);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: one stall drawn per result beat.
    always @(posedge aclk) begin
        int n;
        if (!aresetn) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            n = $urandom_range(0, recv_stall_max);
            stall_left <= n;
            m_ready    <= (n == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            vref_now = VREF_RESET;
            clear_stats();
        end else begin
            if (m_valid && m_ready) begin
                if (report_q.size() == 0) begin
                    bad_reports++;
                    if (bad_reports <= 10)
                        $display("mismatch: result beat with none pending (count %0d)",
                                 m_data.sample_count);
                end else begin
                    want = report_q.pop_front();
                    if (m_data.min_mv !== want.min_mv || m_data.max_mv !== want.max_mv ||
                        m_data.peak_to_peak_mv !== want.peak_to_peak_mv ||
                        m_data.average_mv !== want.average_mv ||
                        m_data.sample_count !== want.sample_count ||
                        m_data.overflowed !== want.overflowed) begin
                        bad_reports++;
                        if (bad_reports <= 10)
                            $display({"mismatch: exp min %0d max %0d pp %0d avg %0d cnt %0d ",
                                      "ovf %0d / got min %0d max %0d pp %0d avg %0d cnt %0d ",
                                      "ovf %0d"},
                                     want.min_mv, want.max_mv, want.peak_to_peak_mv,
                                     want.average_mv, want.sample_count, want.overflowed,
                                     m_data.min_mv, m_data.max_mv, m_data.peak_to_peak_mv,
                                     m_data.average_mv, m_data.sample_count,
                                     m_data.overflowed);
                    end
                end
            end
            if (s_valid && s_ready) absorb_beat(s_data);
            if (cfg_valid && cfg_ready) vref_now = cfg_data;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic queue_beat(input logic op, input logic [CODE_W-1:0] code);
        in_beat_t b;
        while (beat_q.size() >= QUEUE_DEPTH) @(negedge aclk);
        b.operation = op;
        b.sample    = code;
        beat_q.push_back(b);
    endtask

    // Hold until every beat is sent and every report has come back, then settle.
    task automatic drain();
        do @(negedge aclk);
        while (beat_q.size() != 0 || s_valid || report_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_vref(input logic [VREF_W-1:0] v);
        @(posedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic random_phase(input logic [VREF_W-1:0] v, input int gap, input int stall,
                                input int n_beats);
        int k;
        drain();
        write_vref(v);
        send_gap_max   = gap;
        recv_stall_max = stall;
        for (k = 0; k < n_beats; k++) begin
            case ($urandom_range(0, 9))
                0:       queue_beat(OP_REPORT, CODE_W'($urandom));
                1:       queue_beat(OP_ADD, '0);
                2:       queue_beat(OP_ADD, CODE_FS);
                default: queue_beat(OP_ADD, CODE_W'($urandom));
            endcase
        end
        queue_beat(OP_REPORT, '0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        queue_beat(OP_REPORT, CODE_FS);
        queue_beat(OP_ADD, '0);
        queue_beat(OP_ADD, CODE_FS);
        queue_beat(OP_REPORT, '0);
        queue_beat(OP_ADD, CODE_FS);
        queue_beat(OP_REPORT, '0);
        queue_beat(OP_ADD, '0);
        queue_beat(OP_REPORT, CODE_FS);
        queue_beat(OP_ADD, 12'hAAA);
        queue_beat(OP_ADD, 12'h555);
        queue_beat(OP_ADD, 12'h7FF);
        queue_beat(OP_REPORT, 12'h555);
        queue_beat(OP_REPORT, '0);
        queue_beat(OP_REPORT, '0);
        queue_beat(OP_ADD, 12'd1);
        queue_beat(OP_REPORT, '0);

        drain();
        write_vref('0);
        queue_beat(OP_ADD, 12'd1234);
        queue_beat(OP_ADD, CODE_FS);
        queue_beat(OP_REPORT, '0);

        drain();
        write_vref({VREF_W{1'b1}});
        queue_beat(OP_ADD, CODE_FS);
        queue_beat(OP_ADD, '0);
        queue_beat(OP_REPORT, '0);

        random_phase(VREF_W'(5000), 6, 6, 310);
        random_phase(VREF_W'(1000), 0, 0, 310);
        random_phase(VREF_RESET, 2, 6, 310);
        random_phase(VREF_W'($urandom_range(1000, 5000)), 6, 0, 310);
        random_phase({VREF_W{1'b1}}, 6, 6, 310);

        drain();
        if (report_q.size() != 0) bad_reports++;
        if (bad_reports == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
